[sv/sspg_pkg.sv]
`timescale 1ns / 1ps
package sspg_pkg;
	localparam int unsigned H_PIXELS = 320;
	localparam int unsigned V_PIXELS = 240;
	localparam int unsigned COL_W = 9;
	localparam int unsigned ROW_W = 8;
	localparam int unsigned MAX_CHARS = 10;

	typedef logic [15:0] color_t;
	typedef logic [1:0] screen_t;

	localparam screen_t SCR_READY  = 2'd0;
	localparam screen_t SCR_FOUND  = 2'd1;
	localparam screen_t SCR_SAVED  = 2'd2;
	localparam screen_t SCR_UNUSED = 2'd3;

	localparam color_t COL_BG     = {5'd2, 6'd4, 5'd8};
	localparam color_t COL_CARD   = {5'd4, 6'd12, 5'd20};
	localparam color_t COL_EDGE   = {5'd0, 6'd42, 5'd31};
	localparam color_t COL_ACCENT = {5'd0, 6'd58, 5'd9};
	localparam color_t COL_TEXT   = {5'd31, 6'd63, 5'd31};
	localparam color_t COL_MUTED  = {5'd15, 6'd34, 5'd26};

	typedef struct packed {
		logic [3:0] len;
		logic [7:0] top;
		logic [2:0] scale;
		logic [39:0] chars;
	} line_t;

	function automatic logic [4:0] font_row(input logic [3:0] sym, input logic [2:0] gy);
		logic [34:0] g;
		begin
			case (sym)
				4'd1: g = {5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
				4'd2: g = {5'h0f, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0f};
				4'd3: g = {5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e};
				4'd4: g = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f};
				4'd5: g = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h10};
				4'd6: g = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1f};
				4'd7: g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
				4'd8: g = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
				4'd9: g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10};
				4'd10: g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11};
				4'd11: g = {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e};
				4'd12: g = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
				4'd13: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
				4'd14: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0a, 5'h04};
				4'd15: g = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h04, 5'h04, 5'h04};
				default: g = '0;
			endcase
			font_row = (gy < 3'd7) ? g[5'd30 - 5'(gy) * 5'd5 +: 5] : 5'd0;
		end
	endfunction

	function automatic line_t text_line(input logic [2:0] n);
		begin
			case (n)
				3'd0: text_line = '{4'd5, 8'd112, 3'd5, {4'd10, 4'd4, 4'd1, 4'd3, 4'd15, 20'd0}};
				3'd1: text_line = '{4'd6, 8'd155, 3'd5,
					{4'd12, 4'd8, 4'd0, 4'd12, 4'd1, 4'd9, 16'd0}};
				3'd2: text_line = '{4'd10, 8'd112, 3'd4,
					{4'd2, 4'd8, 4'd7, 4'd7, 4'd4, 4'd2, 4'd12, 4'd6, 4'd8, 4'd7}};
				3'd3: text_line = '{4'd5, 8'd153, 3'd6, {4'd5, 4'd8, 4'd13, 4'd7, 4'd3, 20'd0}};
				3'd4: text_line = '{4'd4, 8'd112, 3'd6, {4'd3, 4'd1, 4'd12, 4'd1, 24'd0}};
				3'd5: text_line = '{4'd5, 8'd153, 3'd6, {4'd11, 4'd1, 4'd14, 4'd4, 4'd3, 20'd0}};
				default: text_line = '0;
			endcase
		end
	endfunction
endpackage

[sv/sspg_if.sv]
`timescale 1ns / 1ps
interface sspg_coord_if;
	logic valid;
	logic ready;
	logic [8:0] column;
	logic [7:0] row;
	modport source(output valid, column, row, input ready);
	modport sink(input valid, column, row, output ready);
endinterface

interface sspg_pixel_if;
	logic valid;
	logic ready;
	logic [15:0] pixel_color;
	modport source(output valid, pixel_color, input ready);
	modport sink(input valid, pixel_color, output ready);
endinterface

[sv/sspg_text.sv]
`timescale 1ns / 1ps
module sspg_text (
	input  logic [2:0] line_sel,
	input  logic [8:0] column,
	input  logic [7:0] row,
	output logic       inked
);
	import sspg_pkg::*;
	line_t ln;
	logic [10:0] width;
	logic [9:0] left;
	logic signed [10:0] tx;
	logic signed [9:0] ty;
	logic [8:0] txu;
	logic [6:0] q;
	logic [15:0] q_prod;
	logic [4:0] idx;
	logic [2:0] cc;
	logic [2:0] gy;
	logic [4:0] bits;
	logic ok;

	function automatic logic [8:0] div_scale(input logic [8:0] x, input logic [2:0] sc);
		logic [18:0] p5;
		logic [19:0] p6;
		begin
			p5 = 19'(x) * 19'd205;
			p6 = 20'(x) * 20'd342;
			case (sc)
				3'd4: div_scale = x >> 2;
				3'd5: div_scale = p5[18:10];
				3'd6: div_scale = p6[19:11];
				default: div_scale = 9'd0;
			endcase
		end
	endfunction

	always_comb begin
		ln = text_line(line_sel);
		width = 11'((7'(ln.len) * 7'd6 - 7'd1) * 11'(ln.scale));
		left = 10'd160 - 10'(width >> 1);
		tx = $signed({2'b0, column}) - $signed({1'b0, left});
		ty = $signed({2'b0, row}) - $signed({2'b0, ln.top});
		txu = tx[8:0];
		q = 7'(div_scale(txu, ln.scale));
		gy = 3'(div_scale({1'b0, ty[7:0]}, ln.scale));
		q_prod = 16'(q) * 16'd342;
		idx = q_prod[15:11];
		cc = 3'(q - 7'(idx) * 7'd6);
		ok = !tx[10] && !ty[9] && (ty < $signed(10'(7 * ln.scale)))
			&& tx < 11'sd512 && ln.len != 4'd0 && idx < {1'b0, ln.len} && cc < 3'd5;
		bits = ok ? font_row(ln.chars[6'd36 - 6'(idx) * 6'd4 +: 4], gy) : 5'd0;
		inked = ok && bits[3'd4 - cc];
	end
endmodule

[sv/status_screen_pixel_generator_core.sv]
`timescale 1ns / 1ps
// channel  dir  payload
// coord    in   column[8:0], row[7:0]
// pixel    out  pixel_color[15:0]
// cfg      in   cfg_we, cfg_wdata[1:0] -> screen_select
// One pixel per clock unless pixel.ready stalls the result; stages: input register, then result register.
// Reset empties both stages and sets screen_select to the ready screen.
// A stalled result holds; the input stage advances whenever the result stage frees.
module status_screen_pixel_generator_core (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_wdata,
	sspg_coord_if.sink   coord,
	sspg_pixel_if.source pixel
);
	import sspg_pkg::*;
	screen_t screen_q;
	logic v_s1, v_s2;
	logic [8:0] col_s1;
	logic [7:0] row_s1;
	color_t color_s2, c;
	logic adv2, in0, in1;
	logic signed [9:0] dx;
	logic signed [8:0] dy;
	logic [19:0] r2;

	assign adv2 = !v_s2 || pixel.ready;
	assign coord.ready = !v_s1 || adv2;
	assign pixel.valid = v_s2;
	assign pixel.pixel_color = color_s2;

	sspg_text u_t0 (.line_sel({screen_q, 1'b0}), .column(col_s1), .row(row_s1), .inked(in0));
	sspg_text u_t1 (.line_sel({screen_q, 1'b1}), .column(col_s1), .row(row_s1), .inked(in1));

	always_comb begin
		c = COL_BG;
		dx = $signed({1'b0, col_s1}) - 10'sd160;
		dy = $signed({1'b0, row_s1}) - 9'sd66;
		r2 = 20'(20'(dx) * 20'(dx) + 20'(dy) * 20'(dy));
		if (col_s1 < 9'(H_PIXELS) && 9'(row_s1) < 9'(V_PIXELS)) begin
			if (col_s1 >= 9'd16 && col_s1 < 9'd304 && row_s1 >= 8'd34 && row_s1 < 8'd206) begin
				c = COL_CARD;
				if (col_s1 < 9'd20 || col_s1 >= 9'd300 || row_s1 < 8'd38 || row_s1 >= 8'd202)
					c = COL_EDGE;
			end
			if (r2 < 20'd225) c = (screen_q == SCR_READY) ? COL_MUTED : COL_ACCENT;
			if (row_s1 >= 8'd92 && row_s1 < 8'd95 && col_s1 >= 9'd42 && col_s1 < 9'd278)
				c = COL_MUTED;
			if (screen_q != SCR_UNUSED && (in0 || in1)) c = COL_TEXT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_q <= SCR_READY;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (cfg_we) screen_q <= cfg_wdata;
			if (coord.ready) v_s1 <= coord.valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (coord.ready && coord.valid) begin
			col_s1 <= coord.column;
			row_s1 <= coord.row;
		end
		if (adv2 && v_s1) color_s2 <= c;
	end
endmodule
